// ===== design/lsb_first_bit_window_reader_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the bit window reader checker
// ----------------------------------------------------------------------------
`ifndef LSB_FIRST_BIT_WINDOW_READER_DEFINES_SVH
`define LSB_FIRST_BIT_WINDOW_READER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define LBWR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset
`define LBWR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lbwr_pkg.sv =====
// ----------------------------------------------------------------------------
// lbwr_pkg
// Types and constants of the LSB-first bit window reader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbwr_pkg;

    localparam int WIN_BITS      = 64;
    localparam int WIN_BYTES     = WIN_BITS / 8;
    localparam int VAL_W         = 24;
    localparam int MAX_READ_BITS = 25;

    typedef enum logic [1:0] {
        ACT_STORE  = 2'd0,
        ACT_START  = 2'd1,
        ACT_READ   = 2'd2,
        ACT_SETLEN = 2'd3
    } t_action;

    // Window update request for one cycle
    typedef struct packed {
        logic       clear;
        logic       shift;
        logic       place;
        logic [2:0] idx;
    } t_win_ctl;

endpackage

// ===== design/lbwr_ram.sv =====
// ----------------------------------------------------------------------------
// lbwr_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/lbwr_window.sv =====
// ----------------------------------------------------------------------------
// lbwr_window
// 64-bit prefetch window: byte shift-in at the top, byte placement for the
// initial load, and LSB-first extraction at the current bit position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbwr_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lbwr_pkg::t_win_ctl            i_ctl,
    input  logic [7:0]                    i_byte,
    input  logic [6:0]                    i_bitpos,
    input  logic [4:0]                    i_nbits,
    output logic [lbwr_pkg::VAL_W-1:0]    o_bits
);

    logic [lbwr_pkg::WIN_BITS-1:0] r_window;
    logic [lbwr_pkg::WIN_BITS-1:0] n_window;
    logic [lbwr_pkg::WIN_BITS-1:0] w_shifted;
    logic [31:0]                   w_mask;

    always_comb begin
        n_window = r_window;
        if (i_ctl.clear) begin
            n_window = '0;
        end else if (i_ctl.shift) begin
            n_window = {i_byte, r_window[lbwr_pkg::WIN_BITS-1:8]};
        end else if (i_ctl.place) begin
            n_window[{i_ctl.idx, 3'b000} +: 8] = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else begin
            r_window <= n_window;
        end
    end

    // Bits at or above bit 64 read as zero
    assign w_shifted = r_window >> i_bitpos[5:0];
    assign w_mask    = ~(32'hFFFF_FFFF << i_nbits);
    assign o_bits    = i_bitpos[6] ? '0
                     : (w_shifted[lbwr_pkg::VAL_W-1:0] & w_mask[lbwr_pkg::VAL_W-1:0]);

endmodule

// ===== design/lsb_first_bit_window_reader.sv =====
// ----------------------------------------------------------------------------
// lsb_first_bit_window_reader: store, set length and failed reads need no fill.
// Read: k > 0 bytes to refill go through the fill state, one byte a cycle from the RAM.
// Start: loads min(8, length) bytes when length > 0. Input stalls while an item is busy.
// Reset (sync, low): clears window, positions, length and flags; buffer keeps contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsb_first_bit_window_reader #(
    parameter int BUF_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [11:0] i_byte_addr,
    input  logic [7:0]  i_byte_data,
    input  logic [12:0] i_stream_length,
    input  logic [4:0]  i_nbits,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [23:0] o_bits_value,
    output logic        o_stream_end,
    output logic        o_read_error
);

    localparam int AW = $clog2(BUF_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [6:0]         r_bitpos, n_bitpos;
    logic [12:0]        r_bytepos, n_bytepos;
    logic [12:0]        r_len, n_len;
    logic               r_eos, n_eos;
    logic               r_err, n_err;
    logic [23:0]        r_val, n_val;
    logic [3:0]         r_left, n_left;
    logic [12:0]        r_iss_addr, n_iss_addr;
    logic               r_rd_vld, n_rd_vld;
    logic               r_rd_oob, n_rd_oob;
    logic               r_place, n_place;
    logic               r_out_valid, n_out_valid;
    logic [23:0]        r_out_bits, n_out_bits;
    logic               r_out_eos, n_out_eos;
    logic               r_out_err, n_out_err;

    lbwr_pkg::t_action  w_act;
    lbwr_pkg::t_win_ctl w_win_ctl;
    logic               w_accept;
    logic               w_slot_free;
    logic               w_fin;
    logic [23:0]        w_bits;
    logic [6:0]         w_bitpos_sum;
    logic               w_read_ok;
    logic [12:0]        w_avail;
    logic [3:0]         w_want;
    logic [3:0]         w_read_cnt;
    logic [3:0]         w_start_cnt;
    logic               w_wr_oob;
    logic               w_iss_oob;
    logic [31:0]        w_wr_addr_ext;
    logic [31:0]        w_rd_addr_ext;
    logic               w_wr_en;
    logic               w_rd_en;
    logic [7:0]         w_rd_data;
    logic [7:0]         w_fill_byte;

    assign w_act       = lbwr_pkg::t_action'(i_action);
    assign o_in_stall  = (r_state != ST_IDLE) || !i_rst_n;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;

    assign w_wr_addr_ext = 32'(i_byte_addr);
    assign w_rd_addr_ext = 32'(r_iss_addr);
    assign w_wr_oob      = w_wr_addr_ext >= 32'(BUF_DEPTH);
    assign w_iss_oob     = w_rd_addr_ext >= 32'(BUF_DEPTH);

    assign w_bitpos_sum = r_bitpos + {2'b00, i_nbits};
    assign w_read_ok    = (i_nbits == 5'd0)
                       || (!r_eos && (i_nbits < 5'(lbwr_pkg::MAX_READ_BITS)));
    assign w_avail      = (r_bytepos < r_len) ? (r_len - r_bytepos) : '0;
    assign w_want       = w_bitpos_sum[6:3];
    assign w_read_cnt   = (w_avail < 13'(w_want)) ? w_avail[3:0] : w_want;
    assign w_start_cnt  = (i_stream_length < 13'(lbwr_pkg::WIN_BYTES))
                        ? i_stream_length[3:0] : 4'(lbwr_pkg::WIN_BYTES);
    assign w_fill_byte  = r_rd_oob ? 8'd0 : w_rd_data;

    lbwr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr_ext[AW-1:0]),
        .i_wr_data (i_byte_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr_ext[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    lbwr_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_win_ctl),
        .i_byte   (w_fill_byte),
        .i_bitpos (r_bitpos),
        .i_nbits  (i_nbits),
        .o_bits   (w_bits)
    );

    always_comb begin
        n_state     = r_state;
        n_bitpos    = r_bitpos;
        n_bytepos   = r_bytepos;
        n_len       = r_len;
        n_eos       = r_eos;
        n_err       = r_err;
        n_val       = r_val;
        n_left      = r_left;
        n_iss_addr  = r_iss_addr;
        n_rd_vld    = 1'b0;
        n_rd_oob    = w_iss_oob;
        n_place     = r_place;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_bits  = r_out_bits;
        n_out_eos   = r_out_eos;
        n_out_err   = r_out_err;
        w_win_ctl   = '0;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;
        w_fin       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_act)
                        lbwr_pkg::ACT_STORE: begin
                            w_wr_en = !w_wr_oob;
                            n_val   = '0;
                            w_fin   = 1'b1;
                        end
                        lbwr_pkg::ACT_START: begin
                            n_len           = i_stream_length;
                            n_bytepos       = '0;
                            n_bitpos        = '0;
                            n_eos           = 1'b0;
                            n_err           = 1'b0;
                            n_val           = '0;
                            n_place         = 1'b1;
                            n_iss_addr      = '0;
                            n_left          = w_start_cnt;
                            w_win_ctl.clear = 1'b1;
                            if (w_start_cnt == 4'd0) begin
                                w_fin = 1'b1;
                            end else begin
                                n_state = ST_FILL;
                            end
                        end
                        lbwr_pkg::ACT_READ: begin
                            if (w_read_ok) begin
                                n_val      = w_bits;
                                n_bitpos   = w_bitpos_sum;
                                n_place    = 1'b0;
                                n_iss_addr = r_bytepos;
                                n_left     = w_read_cnt;
                                if ((r_bytepos == r_len)
                                    && (w_bitpos_sum >= 7'(lbwr_pkg::WIN_BITS))) begin
                                    n_eos = 1'b1;
                                end
                                if (w_read_cnt == 4'd0) begin
                                    w_fin = 1'b1;
                                end else begin
                                    n_state = ST_FILL;
                                end
                            end else begin
                                n_err = 1'b1;
                                n_val = '0;
                                w_fin = 1'b1;
                            end
                        end
                        lbwr_pkg::ACT_SETLEN: begin
                            n_eos = (r_bytepos >= i_stream_length);
                            n_len = i_stream_length;
                            n_val = '0;
                            w_fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_FILL: begin
                // issue the next byte read while the previous one lands
                if (r_left != 4'd0) begin
                    w_rd_en    = !w_iss_oob;
                    n_left     = r_left - 4'd1;
                    n_iss_addr = r_iss_addr + 13'd1;
                    n_rd_vld   = 1'b1;
                end else begin
                    w_fin = 1'b1;
                end
                if (r_rd_vld) begin
                    w_win_ctl.shift = !r_place;
                    w_win_ctl.place = r_place;
                    w_win_ctl.idx   = r_bytepos[2:0];
                    n_bytepos       = r_bytepos + 13'd1;
                    if (!r_place) begin
                        n_bitpos = r_bitpos - 7'd8;
                    end
                end
            end
            ST_DONE: begin
                w_fin = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // hand the result to the output register, or hold it until the slot frees
        if (w_fin) begin
            if (w_slot_free) begin
                n_out_valid = 1'b1;
                n_out_bits  = n_val;
                n_out_eos   = n_eos;
                n_out_err   = n_err;
                n_state     = ST_IDLE;
            end else begin
                n_state = ST_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bitpos    <= '0;
            r_bytepos   <= '0;
            r_len       <= '0;
            r_eos       <= 1'b0;
            r_err       <= 1'b0;
            r_left      <= '0;
            r_rd_vld    <= 1'b0;
            r_place     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bitpos    <= n_bitpos;
            r_bytepos   <= n_bytepos;
            r_len       <= n_len;
            r_eos       <= n_eos;
            r_err       <= n_err;
            r_left      <= n_left;
            r_rd_vld    <= n_rd_vld;
            r_place     <= n_place;
            r_out_valid <= n_out_valid;
        end
        r_val      <= n_val;
        r_iss_addr <= n_iss_addr;
        r_rd_oob   <= n_rd_oob;
        r_out_bits <= n_out_bits;
        r_out_eos  <= n_out_eos;
        r_out_err  <= n_out_err;
    end

    assign o_out_valid  = r_out_valid;
    assign o_bits_value = r_out_bits;
    assign o_stream_end = r_out_eos;
    assign o_read_error = r_out_err;

endmodule

// ===== design/lbwr_checker.sv =====
// ----------------------------------------------------------------------------
// lbwr_checker
// Port-level checks of the bit window reader, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lsb_first_bit_window_reader_defines.svh"

module lbwr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_action,
    input logic [11:0] i_byte_addr,
    input logic [7:0]  i_byte_data,
    input logic [12:0] i_stream_length,
    input logic [4:0]  i_nbits,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [23:0] o_bits_value,
    input logic        o_stream_end,
    input logic        o_read_error
);

    logic w_in_acc;
    logic w_slot_free;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_slot_free = !o_out_valid || !i_out_stall;

    `LBWR_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_bits_value) && $stable(o_stream_end) && $stable(o_read_error), "stalled result item changed")

    `LBWR_ASSERT_NEXT(a_quick_result, w_in_acc && w_slot_free && (i_action == lbwr_pkg::ACT_STORE || i_action == lbwr_pkg::ACT_SETLEN), o_out_valid && !o_in_stall, "store or set length item not finished in one cycle")

    `LBWR_ASSERT_NEXT(a_zero_len_eos, w_in_acc && w_slot_free && i_action == lbwr_pkg::ACT_SETLEN && i_stream_length == 13'd0, o_out_valid && o_stream_end && o_bits_value == 24'd0, "zero length did not raise end of stream")

    `LBWR_ASSERT_NEXT(a_start_busy, w_in_acc && i_action == lbwr_pkg::ACT_START && i_stream_length != 13'd0, o_in_stall, "start took a new item during the window load")

    `LBWR_ASSERT_SAME(a_err_zero_bits, o_out_valid && o_read_error && !$stable(o_read_error), o_bits_value == 24'd0, "failed read returned nonzero bits")

endmodule

bind lsb_first_bit_window_reader lbwr_checker u_lbwr_checker (.*);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of lsb_first_bit_window_reader
// Fills the low part of the byte buffer, then runs a typed stimulus table of
// edge cases, then random streams of reads, length changes and stores. Every
// result is checked against its table row's typed result, or else against a
// cycle-free predictor of the reader, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int BUF_BYTES     = 4096;
    localparam int PRELOAD_BYTES = 256;
    localparam int READ_LIMIT    = 200;
    localparam int RESET_CYCLES  = 12;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE        = 24;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 900;

    typedef struct packed {
        logic [23:0] value;
        logic        eos;
        logic        err;
    } t_read_result;

    typedef struct {
        lbwr_pkg::t_action act;
        logic [11:0]       addr;
        logic [7:0]        data;
        logic [12:0]       len;
        logic [4:0]        n;
        bit                typed;
        t_read_result      res;
    } t_script_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_action = lbwr_pkg::ACT_STORE;
    logic [11:0] i_byte_addr = '0;
    logic [7:0]  i_byte_data = '0;
    logic [12:0] i_stream_length = '0;
    logic [4:0]  i_nbits = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [23:0] o_bits_value;
    logic        o_stream_end;
    logic        o_read_error;

    lsb_first_bit_window_reader dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state
    logic [7:0]   buffer_copy [BUF_BYTES];
    logic [63:0]  win_bits = '0;
    logic [6:0]   win_bit_pos = '0;
    logic [12:0]  win_byte_pos = '0;
    logic [12:0]  win_len = '0;
    logic         win_eos = 1'b0;
    logic         win_err = 1'b0;

    t_read_result bits_and_flags_q [$];
    int           mismatch_count = 0;
    int           cycles_run = 0;
    int           items_sent = 0;
    int           burst_left = 0;
    bit           hold_req = 1'b0;

    t_script_row directed_rows [25] = '{
        '{lbwr_pkg::ACT_READ, 12'd0, 8'h00, 13'd0, 5'd0, 1'b1, '{24'h0, 1'b0, 1'b0}},
        '{lbwr_pkg::ACT_READ, 12'd0, 8'h00, 13'd0, 5'd24, 1'b1, '{24'h0, 1'b0, 1'b0}},
        '{lbwr_pkg::ACT_READ, 12'd0, 8'h00, 13'd0, 5'd25, 1'b1, '{24'h0, 1'b0, 1'b1}},
        '{lbwr_pkg::ACT_READ, 12'd0, 8'h00, 13'd0, 5'd31, 1'b1, '{24'h0, 1'b0, 1'b1}},
        '{lbwr_pkg::ACT_SETLEN, 12'd0, 8'h00, 13'd0, 5'd0, 1'b1, '{24'h0, 1'b1, 1'b1}},
        '{lbwr_pkg::ACT_READ, 12'd0, 8'h00, 13'd0, 5'd0, 1'b1, '{24'h0, 1'b1, 1'b1}},
        '{lbwr_pkg::ACT_READ, 12'd0, 8'h00, 13'd0, 5'd1, 1'b1, '{24'h0, 1'b1, 1'b1}},
        '{lbwr_pkg::ACT_STORE, 12'd0, 8'hFF, 13'd0, 5'd0, 1'b1, '{24'h0, 1'b1, 1'b1}},
        '{lbwr_pkg::ACT_STORE, 12'd1, 8'hFF, 13'd0, 5'd0, 1'b1, '{24'h0, 1'b1, 1'b1}},
        '{lbwr_pkg::ACT_STORE, 12'd2, 8'hFF, 13'd0, 5'd0, 1'b1, '{24'h0, 1'b1, 1'b1}},
        '{lbwr_pkg::ACT_STORE, 12'd3, 8'hFF, 13'd0, 5'd0, 1'b1, '{24'h0, 1'b1, 1'b1}},
        '{lbwr_pkg::ACT_STORE, 12'd4, 8'hFF, 13'd0, 5'd0, 1'b1, '{24'h0, 1'b1, 1'b1}},
        '{lbwr_pkg::ACT_STORE, 12'd5, 8'hFF, 13'd0, 5'd0, 1'b1, '{24'h0, 1'b1, 1'b1}},
        '{lbwr_pkg::ACT_STORE, 12'd6, 8'hFF, 13'd0, 5'd0, 1'b1, '{24'h0, 1'b1, 1'b1}},
        '{lbwr_pkg::ACT_STORE, 12'd7, 8'hFF, 13'd0, 5'd0, 1'b1, '{24'h0, 1'b1, 1'b1}},
        '{lbwr_pkg::ACT_STORE, 12'd4095, 8'h00, 13'd0, 5'd0, 1'b1, '{24'h0, 1'b1, 1'b1}},
        '{lbwr_pkg::ACT_START, 12'd0, 8'h00, 13'd8, 5'd0, 1'b1, '{24'h0, 1'b0, 1'b0}},
        '{lbwr_pkg::ACT_READ, 12'd0, 8'h00, 13'd0, 5'd24, 1'b1, '{24'hFFFFFF, 1'b0, 1'b0}},
        '{lbwr_pkg::ACT_READ, 12'd0, 8'h00, 13'd0, 5'd24, 1'b1, '{24'hFFFFFF, 1'b0, 1'b0}},
        '{lbwr_pkg::ACT_READ, 12'd0, 8'h00, 13'd0, 5'd24, 1'b1, '{24'h00FFFF, 1'b1, 1'b0}},
        '{lbwr_pkg::ACT_READ, 12'd0, 8'h00, 13'd0, 5'd1, 1'b1, '{24'h0, 1'b1, 1'b1}},
        '{lbwr_pkg::ACT_SETLEN, 12'd0, 8'h00, 13'd4, 5'd0, 1'b1, '{24'h0, 1'b1, 1'b1}},
        '{lbwr_pkg::ACT_SETLEN, 12'd0, 8'h00, 13'd8191, 5'd0, 1'b1, '{24'h0, 1'b0, 1'b1}},
        '{lbwr_pkg::ACT_READ, 12'd0, 8'h00, 13'd0, 5'd8, 1'b1, '{24'h0, 1'b0, 1'b1}},
        '{lbwr_pkg::ACT_READ, 12'd0, 8'h00, 13'd0, 5'd24, 1'b0, '{24'h0, 1'b0, 1'b0}}
    };

    function automatic logic [7:0] fetch_buffer(logic [12:0] addr);
        if (addr < BUF_BYTES) begin
            return buffer_copy[addr[11:0]];
        end
        return 8'h00;
    endfunction

    function automatic t_read_result step_bit_window(lbwr_pkg::t_action act,
                                                     logic [11:0] addr,
                                                     logic [7:0] data, logic [12:0] len,
                                                     logic [4:0] n);
        t_read_result r;
        logic [63:0]  shifted;
        r = '0;
        case (act)
            lbwr_pkg::ACT_STORE: begin
                buffer_copy[addr] = data;
            end
            lbwr_pkg::ACT_START: begin
                win_len      = len;
                win_bits     = '0;
                win_byte_pos = '0;
                win_bit_pos  = '0;
                win_eos      = 1'b0;
                win_err      = 1'b0;
                for (int i = 0; i < lbwr_pkg::WIN_BYTES && i < win_len; i++) begin
                    win_bits     = win_bits | (64'(fetch_buffer(win_byte_pos)) << (8 * i));
                    win_byte_pos = win_byte_pos + 13'd1;
                end
            end
            lbwr_pkg::ACT_READ: begin
                if (n == 0 || (!win_eos && n < lbwr_pkg::MAX_READ_BITS)) begin
                    // bits at or above bit 64 of the window read as zero
                    if (n != 0 && win_bit_pos < lbwr_pkg::WIN_BITS) begin
                        shifted = win_bits >> win_bit_pos;
                        r.value = shifted[23:0] & ((24'd1 << n) - 24'd1);
                    end
                    win_bit_pos = win_bit_pos + 7'(n);
                    if (win_byte_pos == win_len && win_bit_pos >= lbwr_pkg::WIN_BITS) begin
                        win_eos = 1'b1;
                    end
                    while (win_bit_pos >= 8 && win_byte_pos < win_len) begin
                        win_bits     = {fetch_buffer(win_byte_pos), win_bits[63:8]};
                        win_byte_pos = win_byte_pos + 13'd1;
                        win_bit_pos  = win_bit_pos - 7'd8;
                    end
                end else begin
                    win_err = 1'b1;
                end
            end
            default: begin
                win_eos = (win_byte_pos >= len);
                win_len = len;
            end
        endcase
        r.eos = win_eos;
        r.err = win_err;
        return r;
    endfunction

    task automatic offer(input lbwr_pkg::t_action act, input logic [11:0] addr,
                         input logic [7:0] data,
                         input logic [12:0] len, input logic [4:0] n,
                         input bit typed = 1'b0, input t_read_result typed_res = '0);
        int           idle;
        t_read_result predicted;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(1, 12);
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (idle) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_byte_addr     <= addr;
        i_byte_data     <= data;
        i_stream_length <= len;
        i_nbits         <= n;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = step_bit_window(act, addr, data, len, n);
        bits_and_flags_q.push_back(typed ? typed_res : predicted);
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (bits_and_flags_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [4:0] pick_read_bits();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 5'd0;
        end
        if (r <= 3) begin
            return 5'd24;
        end
        return 5'($urandom_range(1, 23));
    endfunction

    // Receiver: stall pattern changes mode every stretch; honors a long hold request
    initial begin
        int mode;
        int span;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(negedge i_clk);
                if (hold_req) begin
                    i_out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                    hold_req = 1'b0;
                end
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 99) < 30);
                    2: i_out_stall <= ($urandom_range(0, 99) < 75);
                    default: i_out_stall <= ((cycles_run % 7) < 3);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_read_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (bits_and_flags_q.size() == 0) begin
                $display("%0t: result with nothing pending: bits %h eos %b err %b",
                         $time, o_bits_value, o_stream_end, o_read_error);
                mismatch_count++;
            end else begin
                want = bits_and_flags_q.pop_front();
                if (o_bits_value !== want.value) begin
                    $display("%0t: bits_value expected %h, got %h",
                             $time, want.value, o_bits_value);
                    mismatch_count++;
                end
                if (o_stream_end !== want.eos) begin
                    $display("%0t: stream end flag expected %b, got %b",
                             $time, want.eos, o_stream_end);
                    mismatch_count++;
                end
                if (o_read_error !== want.err) begin
                    $display("%0t: read_error expected %b, got %b",
                             $time, want.err, o_read_error);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles_run++;
        if (cycles_run > CYCLE_LIMIT) begin
            $display("lsb_first_bit_window_reader verification failed");
            $finish;
        end
    end

    initial begin
        int                episode;
        int                reads;
        int                r;
        int                random_end;
        logic [12:0]       ln;
        lbwr_pkg::t_action act;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Write the low buffer bytes so that no fetch ever hits an unwritten entry
        for (int a = 0; a < PRELOAD_BYTES; a++) begin
            offer(lbwr_pkg::ACT_STORE, 12'(a), 8'($urandom), 13'($urandom), 5'($urandom));
        end
        drain_results();

        foreach (directed_rows[i]) begin
            offer(directed_rows[i].act, directed_rows[i].addr, directed_rows[i].data,
                  directed_rows[i].len, directed_rows[i].n,
                  directed_rows[i].typed, directed_rows[i].res);
        end
        drain_results();

        episode    = 0;
        random_end = items_sent + RANDOM_ITEMS;
        while (items_sent < random_end) begin
            if (episode == 3) begin
                hold_req   = 1'b1;
                burst_left = 80;
            end
            if ($urandom_range(0, 9) == 0) begin
                act = lbwr_pkg::t_action'($urandom_range(0, 3));
                // restart rather than read on past the preloaded bytes
                if (act == lbwr_pkg::ACT_READ && win_byte_pos > 13'(READ_LIMIT)) begin
                    act = lbwr_pkg::ACT_START;
                end
                offer(act, 12'($urandom), 8'($urandom), 13'($urandom), 5'($urandom));
            end else begin
                repeat ($urandom_range(0, 4)) begin
                    offer(lbwr_pkg::ACT_STORE,
                          ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 63))
                                                      : 12'($urandom),
                          8'($urandom), 13'($urandom), 5'($urandom));
                end
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    ln = 13'($urandom_range(0, 24));
                end else if (r < 85) begin
                    ln = 13'($urandom_range(25, 300));
                end else if (r < 95) begin
                    ln = 13'($urandom_range(301, BUF_BYTES));
                end else begin
                    ln = 13'($urandom_range(BUF_BYTES + 1, 8191));
                end
                offer(lbwr_pkg::ACT_START, 12'($urandom), 8'($urandom), ln, 5'($urandom));
                reads = $urandom_range(1, 30);
                repeat (reads) begin
                    r = $urandom_range(0, 99);
                    if (r < 80) begin
                        offer(lbwr_pkg::ACT_READ, 12'($urandom), 8'($urandom),
                              13'($urandom), pick_read_bits());
                    end else if (r < 88) begin
                        offer(lbwr_pkg::ACT_READ, 12'($urandom), 8'($urandom),
                              13'($urandom),
                              5'($urandom_range(lbwr_pkg::MAX_READ_BITS, 31)));
                    end else if (r < 94) begin
                        // move the length around the current byte position
                        ln = ($urandom_range(0, 3) == 0) ? 13'($urandom)
                             : win_byte_pos + 13'($urandom_range(0, 6)) - 13'd3;
                        offer(lbwr_pkg::ACT_SETLEN, 12'($urandom), 8'($urandom), ln,
                              5'($urandom));
                    end else begin
                        offer(lbwr_pkg::ACT_STORE, 12'($urandom), 8'($urandom),
                              13'($urandom), 5'($urandom));
                    end
                end
            end
            episode++;
        end

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("lsb_first_bit_window_reader verification clean");
        end else begin
            $display("lsb_first_bit_window_reader verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/lbwr_pkg.sv
design/lbwr_ram.sv
design/lbwr_window.sv
design/lsb_first_bit_window_reader.sv
design/lbwr_checker.sv
tb/sv/tb_top.sv
